### sv/asf_pkg.sv
package asf_pkg;

  localparam int SQRT_IN_W = 50;
  localparam int SQRT_BITS = 25;
  localparam int DIV_NUM_W = 44;
  localparam int DIV_DEN_W = 25;
  localparam int QUO_BITS = 19;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W = 28;
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [18:0] MAX_SPEED_RST = 19'd25600;
  localparam logic [18:0] MAX_ACCEL_RST = 19'd25600;
  localparam logic [22:0] EASE_RADIUS_RST = 23'd25600;
  localparam logic [22:0] STOP_RADIUS_RST = 23'd1280;
  localparam logic [14:0] TURN_STEP_RST = 15'd910;
  localparam logic [14:0] SNAP_WINDOW_RST = 15'd1820;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPEED   = 3'd0,
    CFG_MAX_ACCEL   = 3'd1,
    CFG_EASE_RADIUS = 3'd2,
    CFG_STOP_RADIUS = 3'd3,
    CFG_TURN_STEP   = 3'd4,
    CFG_SNAP_WINDOW = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [19:0] vel_x;
    logic signed [19:0] vel_y;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [15:0]        facing;
  } in_t;

  typedef struct packed {
    logic signed [19:0] acc_x;
    logic signed [19:0] acc_y;
    logic [15:0]        new_facing;
    logic               stopped;
  } out_t;

endpackage

### sv/asf_isqrt.sv
module asf_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [asf_pkg::SQRT_IN_W-1:0]   n,
  output logic                            out_valid,
  output logic [asf_pkg::SQRT_BITS-1:0]   root
);

  localparam int RW = asf_pkg::SQRT_IN_W + 2;
  localparam int NB = asf_pkg::SQRT_BITS;

  logic [RW-1:0] rem_q [NB];
  logic [NB-1:0] root_q [NB];
  logic          vld [NB];

  // one root bit per stage, msb first
  for (genvar k = 0; k < NB; k++) begin : g_st
    localparam int B = NB - 1 - k;
    logic [RW-1:0] rem_in;
    logic [NB-1:0] r_in;
    logic          v_in;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = RW'(n);
      assign r_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign r_in = root_q[k-1];
      assign v_in = vld[k-1];
    end

    assign trial = (RW'(r_in) << (B + 1)) + (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_q[k] <= rem_in - trial;
        root_q[k] <= r_in | (NB'(1) << B);
      end else begin
        rem_q[k] <= rem_in;
        root_q[k] <= r_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
    end
  end

  assign out_valid = vld[NB-1];
  assign root = root_q[NB-1];

endmodule

### sv/asf_div.sv
module asf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [asf_pkg::DIV_NUM_W-1:0]   num,
  input  logic [asf_pkg::DIV_DEN_W-1:0]   den,
  output logic                            out_valid,
  output logic [asf_pkg::QUO_BITS-1:0]    quo
);

  localparam int NW = asf_pkg::DIV_NUM_W;
  localparam int DW = asf_pkg::DIV_DEN_W;
  localparam int QB = asf_pkg::QUO_BITS;
  localparam int CW = NW + 1;

  logic [NW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic          vld [QB];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_st
    localparam int B = QB - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] q_in;
    logic          v_in;
    logic [CW-1:0] dsh;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign q_in = quo_q[k-1];
      assign v_in = vld[k-1];
    end

    assign dsh = CW'(den_in) << B;

    always_ff @(posedge clk) begin
      den_q[k] <= den_in;
      if (CW'(rem_in) >= dsh) begin
        rem_q[k] <= NW'(CW'(rem_in) - dsh);
        quo_q[k] <= q_in | (QB'(1) << B);
      end else begin
        rem_q[k] <= rem_in;
        quo_q[k] <= q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
    end
  end

  assign out_valid = vld[QB-1];
  assign quo = quo_q[QB-1];

endmodule

### sv/asf_cordic.sv
module asf_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [24:0] x_in,
  input  logic signed [24:0] y_in,
  output logic               out_valid,
  output logic [15:0]        heading
);

  localparam int W = asf_pkg::CORDIC_W;
  localparam int NS = asf_pkg::CORDIC_STEPS;

  logic signed [W-1:0] x_q [NS+1];
  logic signed [W-1:0] y_q [NS+1];
  logic [31:0]         z_q [NS+1];
  logic                vld [NS+1];
  logic [31:0]         z_rnd;

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (x_in < 0) begin
      x_q[0] <= -W'(x_in);
      y_q[0] <= -W'(y_in);
      z_q[0] <= 32'h80000000;
    end else begin
      x_q[0] <= W'(x_in);
      y_q[0] <= W'(y_in);
      z_q[0] <= 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_it
    localparam int I = k - 1;
    always_ff @(posedge clk) begin
      if (y_q[k-1] >= 0) begin
        x_q[k] <= x_q[k-1] + (y_q[k-1] >>> I);
        y_q[k] <= y_q[k-1] - (x_q[k-1] >>> I);
        z_q[k] <= z_q[k-1] + asf_pkg::ATAN_TAB[I];
      end else begin
        x_q[k] <= x_q[k-1] - (y_q[k-1] >>> I);
        y_q[k] <= y_q[k-1] + (x_q[k-1] >>> I);
        z_q[k] <= z_q[k-1] - asf_pkg::ATAN_TAB[I];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // round to 16-bit units, then add a quarter turn
  assign z_rnd = z_q[NS] + 32'h00008000;
  assign heading = z_rnd[31:16] + 16'd16384;
  assign out_valid = vld[NS];

endmodule

### sv/arrive_steer_and_face_top.sv
// pipeline: two 25-stage square roots, three levels of 19-stage dividers
//   and ten glue stages
// throughput: one item per cycle, busy stays low
// reset: clears all valid bits and loads the register defaults
// the receiver cannot stall, every result is shown for exactly one cycle
module arrive_steer_and_face_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  asf_pkg::in_t                     cmd,
  output logic                             done,
  output asf_pkg::out_t                    result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [asf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [asf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SB = asf_pkg::SQRT_BITS;
  localparam int QB = asf_pkg::QUO_BITS;
  localparam int HD = SB + 2 - asf_pkg::CORDIC_LAT;
  localparam int LAT = 10 + 2 * SB + 3 * QB;

  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic [15:0]        facing;
  } geo_t;

  typedef struct packed {
    geo_t        geo;
    logic [15:0] heading;
    logic [24:0] tgt_len;
    logic        stopped;
    logic        fast;
  } spd_t;

  typedef struct packed {
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic [15:0]        facing;
    logic [15:0]        heading;
    logic               stopped;
    logic               sx;
    logic               sy;
  } vel_t;

  typedef struct packed {
    logic signed [25:0] ax;
    logic signed [25:0] ay;
    logic [15:0]        facing;
    logic [15:0]        heading;
    logic               stopped;
  } acc_t;

  // configuration
  logic [18:0] max_speed;
  logic [18:0] max_accel;
  logic [22:0] ease_radius;
  logic [22:0] stop_radius;
  logic [14:0] turn_step;
  logic [14:0] snap_window;

  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= asf_pkg::MAX_SPEED_RST;
      max_accel <= asf_pkg::MAX_ACCEL_RST;
      ease_radius <= asf_pkg::EASE_RADIUS_RST;
      stop_radius <= asf_pkg::STOP_RADIUS_RST;
      turn_step <= asf_pkg::TURN_STEP_RST;
      snap_window <= asf_pkg::SNAP_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        asf_pkg::CFG_MAX_SPEED:   max_speed <= cfg_data[18:0];
        asf_pkg::CFG_MAX_ACCEL:   max_accel <= cfg_data[18:0];
        asf_pkg::CFG_EASE_RADIUS: ease_radius <= cfg_data[22:0];
        asf_pkg::CFG_STOP_RADIUS: stop_radius <= cfg_data[22:0];
        asf_pkg::CFG_TURN_STEP:   turn_step <= cfg_data[14:0];
        asf_pkg::CFG_SNAP_WINDOW: snap_window <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // p1: offsets
  logic p1_v, p2_v, p3_v;
  geo_t p1_geo, p2_geo, p3_geo;
  logic [48:0] p2_dxx, p2_dyy;
  logic [asf_pkg::SQRT_IN_W-1:0] p3_n;

  always_ff @(posedge clk) begin
    p1_geo.dx <= 25'(cmd.target_x) - 25'(cmd.pos_x);
    p1_geo.dy <= 25'(cmd.target_y) - 25'(cmd.pos_y);
    p1_geo.vx <= cmd.vel_x;
    p1_geo.vy <= cmd.vel_y;
    p1_geo.facing <= cmd.facing;
    p2_geo <= p1_geo;
    p2_dxx <= 49'(p1_geo.dx * p1_geo.dx);
    p2_dyy <= 49'(p1_geo.dy * p1_geo.dy);
    p3_geo <= p2_geo;
    p3_n <= 50'(p2_dxx) + 50'(p2_dyy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= start && !busy;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  // heading runs beside the distance root
  logic        cor_v;
  logic [15:0] cor_heading;
  logic [15:0] hd_dl [HD];

  asf_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_v),
    .x_in      (p1_geo.dx),
    .y_in      (p1_geo.dy),
    .out_valid (cor_v),
    .heading   (cor_heading)
  );

  always_ff @(posedge clk) begin
    hd_dl[0] <= cor_heading;
    for (int k = 1; k < HD; k++) hd_dl[k] <= hd_dl[k-1];
  end

  // distance
  logic          sq1_v;
  logic [SB-1:0] tgt_len;
  geo_t          geo_dl [SB];

  asf_isqrt u_sqrt_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p3_v),
    .n         (p3_n),
    .out_valid (sq1_v),
    .root      (tgt_len)
  );

  always_ff @(posedge clk) begin
    geo_dl[0] <= p3_geo;
    for (int k = 1; k < SB; k++) geo_dl[k] <= geo_dl[k-1];
  end

  // s4: stop test and speed numerator
  logic s4_v;
  spd_t s4;
  logic [asf_pkg::DIV_NUM_W-1:0] s4_prod;

  always_ff @(posedge clk) begin
    s4.geo <= geo_dl[SB-1];
    s4.heading <= hd_dl[HD-1];
    s4.tgt_len <= tgt_len;
    s4.stopped <= tgt_len <= 25'(stop_radius);
    s4.fast <= (ease_radius == '0) || (tgt_len > 25'(ease_radius));
    s4_prod <= 44'(max_speed) * 44'(tgt_len);
  end

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else s4_v <= sq1_v;
  end

  logic          dv1_v;
  logic [QB-1:0] q_speed;
  spd_t          spd_dl [QB];

  asf_div u_div_speed (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_v),
    .num       (s4_prod),
    .den       (25'(ease_radius)),
    .out_valid (dv1_v),
    .quo       (q_speed)
  );

  always_ff @(posedge clk) begin
    spd_dl[0] <= s4;
    for (int k = 1; k < QB; k++) spd_dl[k] <= spd_dl[k-1];
  end

  // s5: direction numerators
  spd_t        sp;
  logic [18:0] speed;
  logic [24:0] mag_dx, mag_dy;
  logic        s5_v;
  vel_t        s5;
  logic [24:0] s5_dist;
  logic [asf_pkg::DIV_NUM_W-1:0] s5_nx, s5_ny;

  assign sp = spd_dl[QB-1];
  assign speed = sp.fast ? max_speed : q_speed;
  assign mag_dx = sp.geo.dx[24] ? 25'(-sp.geo.dx) : 25'(sp.geo.dx);
  assign mag_dy = sp.geo.dy[24] ? 25'(-sp.geo.dy) : 25'(sp.geo.dy);

  always_ff @(posedge clk) begin
    s5.vx <= sp.geo.vx;
    s5.vy <= sp.geo.vy;
    s5.facing <= sp.geo.facing;
    s5.heading <= sp.heading;
    s5.stopped <= sp.stopped;
    s5.sx <= sp.geo.dx[24];
    s5.sy <= sp.geo.dy[24];
    s5_dist <= sp.tgt_len;
    s5_nx <= 44'(mag_dx) * 44'(speed);
    s5_ny <= 44'(mag_dy) * 44'(speed);
  end

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else s5_v <= dv1_v;
  end

  logic          dvx_v, dvy_v;
  logic [QB-1:0] q_tx, q_ty;
  vel_t          vel_dl [QB];

  asf_div u_div_tx (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_v),
    .num       (s5_nx),
    .den       (s5_dist),
    .out_valid (dvx_v),
    .quo       (q_tx)
  );

  asf_div u_div_ty (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_v),
    .num       (s5_ny),
    .den       (s5_dist),
    .out_valid (dvy_v),
    .quo       (q_ty)
  );

  always_ff @(posedge clk) begin
    vel_dl[0] <= s5;
    for (int k = 1; k < QB; k++) vel_dl[k] <= vel_dl[k-1];
  end

  // s6: acceleration before clamp
  vel_t vl;
  logic signed [20:0] tx, ty;
  logic signed [21:0] ex, ey;
  logic s6_v, s7_v, s8_v;
  acc_t s6, s7, s8;
  logic [49:0] s7_axx, s7_ayy;
  logic [asf_pkg::SQRT_IN_W-1:0] s8_n;

  assign vl = vel_dl[QB-1];
  assign tx = vl.sx ? -21'(q_tx) : 21'(q_tx);
  assign ty = vl.sy ? -21'(q_ty) : 21'(q_ty);
  assign ex = 22'(tx) - 22'(vl.vx);
  assign ey = 22'(ty) - 22'(vl.vy);

  always_ff @(posedge clk) begin
    s6.ax <= 26'(ex) * 26'sd10;
    s6.ay <= 26'(ey) * 26'sd10;
    s6.facing <= vl.facing;
    s6.heading <= vl.heading;
    s6.stopped <= vl.stopped;
    s7 <= s6;
    s7_axx <= 50'(s6.ax * s6.ax);
    s7_ayy <= 50'(s6.ay * s6.ay);
    s8 <= s7;
    s8_n <= s7_axx + s7_ayy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      s8_v <= 1'b0;
    end else begin
      s6_v <= dvx_v && dvy_v;
      s7_v <= s6_v;
      s8_v <= s7_v;
    end
  end

  logic          sq2_v;
  logic [SB-1:0] mag;
  acc_t          acc_dl [SB];

  asf_isqrt u_sqrt_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s8_v),
    .n         (s8_n),
    .out_valid (sq2_v),
    .root      (mag)
  );

  always_ff @(posedge clk) begin
    acc_dl[0] <= s8;
    for (int k = 1; k < SB; k++) acc_dl[k] <= acc_dl[k-1];
  end

  // s9: clamp numerators
  acc_t        ac;
  logic [24:0] mag_ax, mag_ay;
  logic        s9_v;
  acc_t        s9;
  logic        s9_clamp;
  logic [24:0] s9_mag;
  logic [asf_pkg::DIV_NUM_W-1:0] s9_nx, s9_ny;

  assign ac = acc_dl[SB-1];
  assign mag_ax = ac.ax[25] ? 25'(-ac.ax) : 25'(ac.ax);
  assign mag_ay = ac.ay[25] ? 25'(-ac.ay) : 25'(ac.ay);

  always_ff @(posedge clk) begin
    s9 <= ac;
    s9_clamp <= mag > 25'(max_accel);
    s9_mag <= mag;
    s9_nx <= 44'(mag_ax) * 44'(max_accel);
    s9_ny <= 44'(mag_ay) * 44'(max_accel);
  end

  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else s9_v <= sq2_v;
  end

  logic          dcx_v, dcy_v;
  logic [QB-1:0] q_cx, q_cy;
  acc_t          cl_dl [QB];
  logic          clamp_dl [QB];

  asf_div u_div_cx (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s9_v),
    .num       (s9_nx),
    .den       (s9_mag),
    .out_valid (dcx_v),
    .quo       (q_cx)
  );

  asf_div u_div_cy (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s9_v),
    .num       (s9_ny),
    .den       (s9_mag),
    .out_valid (dcy_v),
    .quo       (q_cy)
  );

  always_ff @(posedge clk) begin
    cl_dl[0] <= s9;
    clamp_dl[0] <= s9_clamp;
    for (int k = 1; k < QB; k++) begin
      cl_dl[k] <= cl_dl[k-1];
      clamp_dl[k] <= clamp_dl[k-1];
    end
  end

  // s10: final clamp, saturation and facing
  acc_t               fc;
  logic               fclamp;
  logic signed [25:0] fx, fy;
  logic signed [19:0] sat_x, sat_y;
  logic [15:0]        dang;
  logic [15:0]        err;
  logic [15:0]        nf;

  assign fc = cl_dl[QB-1];
  assign fclamp = clamp_dl[QB-1];
  assign fx = fclamp ? (fc.ax[25] ? -26'(q_cx) : 26'(q_cx)) : fc.ax;
  assign fy = fclamp ? (fc.ay[25] ? -26'(q_cy) : 26'(q_cy)) : fc.ay;
  assign sat_x = (fx > 26'sd524287) ? 20'sd524287 :
                 (fx < -26'sd524288) ? -20'sd524288 : fx[19:0];
  assign sat_y = (fy > 26'sd524287) ? 20'sd524287 :
                 (fy < -26'sd524288) ? -20'sd524288 : fy[19:0];

  // short-way error; half a turn counts as a positive turn
  assign dang = fc.heading - fc.facing;
  assign err = (dang <= 16'd32768) ? dang : 16'(17'd65536 - 17'(dang));

  always_comb begin
    if (err < 16'(snap_window)) nf = fc.heading;
    else if (dang <= 16'd32768) nf = fc.facing + 16'(turn_step);
    else nf = fc.facing - 16'(turn_step);
  end

  always_ff @(posedge clk) begin
    if (fc.stopped) begin
      result.acc_x <= '0;
      result.acc_y <= '0;
      result.new_facing <= fc.facing;
      result.stopped <= 1'b1;
    end else begin
      result.acc_x <= sat_x;
      result.acc_y <= sat_y;
      result.new_facing <= nf;
      result.stopped <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dcx_v && dcy_v;
  end

  // checks
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.stopped |-> result.acc_x == '0 && result.acc_y == '0)
    else $error("stopped item with nonzero acceleration");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    done && !result.stopped |->
      (21'(result.acc_x) <= $signed({2'b00, max_accel}))
      && (21'(result.acc_x) >= -$signed({2'b00, max_accel}))
      && (21'(result.acc_y) <= $signed({2'b00, max_accel}))
      && (21'(result.acc_y) >= -$signed({2'b00, max_accel})))
    else $error("acceleration exceeds clamp");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without item accepted at pipeline depth");

  a_heading_align: assert property (@(posedge clk) disable iff (rst)
    cor_v |-> $past(p1_v, asf_pkg::CORDIC_LAT))
    else $error("heading valid out of step with offsets");

endmodule

### tb/arrive_steer_and_face_top_tb.sv
`timescale 1ns / 100ps

module arrive_steer_and_face_top_tb;

  localparam int LATENCY = 117;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  asf_pkg::in_t cmd;
  logic done;
  asf_pkg::out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [asf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [asf_pkg::CFG_DATA_W-1:0] cfg_data;

  arrive_steer_and_face_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  longint unsigned max_speed_q, max_accel_q, ease_radius_q, stop_radius_q;
  longint unsigned turn_step_q, snap_window_q;

  asf_pkg::in_t cmd_queue[$];
  asf_pkg::out_t expected_steer[$];
  int send_idle_pct;
  int errors;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint scaled(longint a, longint unsigned mul, longint unsigned den);
    longint unsigned m;
    m = (a < 0 ? -a : a) * mul / den;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic logic [15:0] cordic_angle(longint x, longint y);
    logic [31:0] z;
    longint nx;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < asf_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += asf_pkg::ATAN_TAB[i];
      end else begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= asf_pkg::ATAN_TAB[i];
      end
      x = nx;
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  function automatic asf_pkg::out_t steer_predict(asf_pkg::in_t c);
    asf_pkg::out_t o;
    longint dx, dy, tx, ty, ax, ay;
    longint unsigned tgt_len, speed, mag, err;
    logic [15:0] heading, d;
    dx = longint'(c.target_x) - longint'(c.pos_x);
    dy = longint'(c.target_y) - longint'(c.pos_y);
    tgt_len = int_sqrt(dx * dx + dy * dy);
    o.stopped = 1'b0;
    if (tgt_len <= stop_radius_q) begin
      o.acc_x = '0;
      o.acc_y = '0;
      o.new_facing = c.facing;
      o.stopped = 1'b1;
      return o;
    end
    if (ease_radius_q == 0 || tgt_len > ease_radius_q) speed = max_speed_q;
    else speed = max_speed_q * tgt_len / ease_radius_q;
    tx = 0;
    ty = 0;
    if (tgt_len != 0) begin
      tx = scaled(dx, speed, tgt_len);
      ty = scaled(dy, speed, tgt_len);
    end
    ax = (tx - longint'(c.vel_x)) * 10;
    ay = (ty - longint'(c.vel_y)) * 10;
    mag = int_sqrt(ax * ax + ay * ay);
    if (mag > max_accel_q) begin
      ax = scaled(ax, max_accel_q, mag);
      ay = scaled(ay, max_accel_q, mag);
    end
    ax = sat20(ax);
    ay = sat20(ay);
    o.acc_x = ax[19:0];
    o.acc_y = ay[19:0];
    heading = cordic_angle(dx, dy) + 16'd16384;
    d = heading - c.facing;
    err = d <= 16'd32768 ? d : 65536 - d;
    if (err < snap_window_q) o.new_facing = heading;
    else if (d <= 16'd32768) o.new_facing = c.facing + 16'(turn_step_q);
    else o.new_facing = c.facing - 16'(turn_step_q);
    return o;
  endfunction

  function automatic asf_pkg::in_t rand_cmd(int span);
    asf_pkg::in_t c;
    int unsigned base;
    c.pos_x = $urandom;
    c.pos_y = $urandom;
    c.vel_x = $urandom;
    c.vel_y = $urandom;
    c.facing = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        c.target_x = $urandom;
        c.target_y = $urandom;
      end
      default: begin
        // near targets to hit the slow and stop radii
        base = $urandom_range(1, span);
        c.vel_x = $signed(20'($urandom_range(0, 60000))) - 20'sd30000;
        c.vel_y = $signed(20'($urandom_range(0, 60000))) - 20'sd30000;
        c.target_x = c.pos_x + 24'($urandom_range(0, 2 * base)) - 24'(base);
        c.target_y = c.pos_y + 24'($urandom_range(0, 2 * base)) - 24'(base);
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(asf_pkg::cfg_idx_t idx, logic [asf_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      asf_pkg::CFG_MAX_SPEED: max_speed_q = val & 23'h7FFFF;
      asf_pkg::CFG_MAX_ACCEL: max_accel_q = val & 23'h7FFFF;
      asf_pkg::CFG_EASE_RADIUS: ease_radius_q = val;
      asf_pkg::CFG_STOP_RADIUS: stop_radius_q = val;
      asf_pkg::CFG_TURN_STEP: turn_step_q = val & 23'h7FFF;
      asf_pkg::CFG_SNAP_WINDOW: snap_window_q = val & 23'h7FFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    while (cmd_queue.size() != 0 || expected_steer.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_all(int ms, int ma, int sr, int st, int ts, int sw);
    write_reg(asf_pkg::CFG_MAX_SPEED, ms);
    write_reg(asf_pkg::CFG_MAX_ACCEL, ma);
    write_reg(asf_pkg::CFG_EASE_RADIUS, sr);
    write_reg(asf_pkg::CFG_STOP_RADIUS, st);
    write_reg(asf_pkg::CFG_TURN_STEP, ts);
    write_reg(asf_pkg::CFG_SNAP_WINDOW, sw);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      cmd_queue.pop_front();
      expected_steer.push_back(steer_predict(cmd));
      if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd <= cmd_queue[0];
      end else begin
        start <= 1'b0;
      end
    end else if (!start && cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      cmd <= cmd_queue[0];
      start <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    asf_pkg::out_t exp_r;
    if (!rst && done) begin
      if (expected_steer.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = expected_steer.pop_front();
        if (result.acc_x !== exp_r.acc_x) begin
          $error("acc_x expected %0d got %0d", exp_r.acc_x, result.acc_x);
          errors++;
        end
        if (result.acc_y !== exp_r.acc_y) begin
          $error("acc_y expected %0d got %0d", exp_r.acc_y, result.acc_y);
          errors++;
        end
        if (result.new_facing !== exp_r.new_facing) begin
          $error("new_facing expected %0d got %0d", exp_r.new_facing, result.new_facing);
          errors++;
        end
        if (result.stopped !== exp_r.stopped) begin
          $error("stopped expected %0d got %0d", exp_r.stopped, result.stopped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("arrive_steer_and_face_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    asf_pkg::in_t c;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 26;
    max_speed_q = asf_pkg::MAX_SPEED_RST;
    max_accel_q = asf_pkg::MAX_ACCEL_RST;
    ease_radius_q = asf_pkg::EASE_RADIUS_RST;
    stop_radius_q = asf_pkg::STOP_RADIUS_RST;
    turn_step_q = asf_pkg::TURN_STEP_RST;
    snap_window_q = asf_pkg::SNAP_WINDOW_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, stop, slow zone, half-turn error
    c = '0;
    cmd_queue.push_back(c);
    c.facing = 16'hFFFF; c.target_x = 24'sd1280;
    cmd_queue.push_back(c);
    c.target_x = 24'sd1281;
    cmd_queue.push_back(c);
    c = '0; c.target_x = 24'sd10000; c.facing = 16'd49152;
    cmd_queue.push_back(c);
    c.facing = 16'd0;
    cmd_queue.push_back(c);
    c = '0; c.pos_x = 24'h800000; c.pos_y = 24'h800000;
    c.target_x = 24'h7FFFFF; c.target_y = 24'h7FFFFF;
    c.vel_x = 20'h80000; c.vel_y = 20'h7FFFF;
    cmd_queue.push_back(c);
    c = '0; c.pos_x = 24'h7FFFFF; c.target_x = 24'h800000;
    c.vel_x = 20'h7FFFF; c.vel_y = 20'h80000; c.facing = 16'h8000;
    cmd_queue.push_back(c);
    c = '0; c.target_y = -24'sd5000; c.vel_x = 20'sd100;
    cmd_queue.push_back(c);
    c = '0; c.target_x = -24'sd3000; c.target_y = 24'sd3000; c.facing = 16'd60000;
    cmd_queue.push_back(c);
    for (int i = 0; i < 10; i++) cmd_queue.push_back(rand_cmd(40000));
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = phase < 2 ? 26 : (phase < 4 ? 58 : 0);
      case (phase)
        0: set_all(0, 0, 1, 1, 0, 0);
        1: set_all(524287, 524287, 8388607, 8388607, 32767, 32767);
        2: set_all(25600, 524287, 40000, 0, 910, 0);
        3: set_all($urandom_range(0, 524287), $urandom_range(0, 524287),
                   $urandom_range(1, 60000), $urandom_range(1, 3000),
                   $urandom_range(0, 32767), $urandom_range(0, 32767));
        4: set_all(30000, 20000, 0, 500, 32767, 1000);
        default: set_all(25600, 25600, 25600, 1280, 910, 1820);
      endcase
      // out-of-range index is ignored
      if (phase == 5) write_reg(asf_pkg::cfg_idx_t'(3'd7), 23'h7FFFFF);
      for (int i = 0; i < 67; i++)
        cmd_queue.push_back(rand_cmd(phase == 1 ? 8000000 : 60000));
      settle();
    end

    if (errors == 0) begin
      $display("arrive_steer_and_face_top_tb OK");
    end else begin
      $display("arrive_steer_and_face_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
sv/asf_pkg.sv
sv/asf_isqrt.sv
sv/asf_div.sv
sv/asf_cordic.sv
sv/arrive_steer_and_face_top.sv
tb/arrive_steer_and_face_top_tb.sv
